[rtl/utf8d_pkg.sv]
package utf8d_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 16;
    localparam int PENDING_W = 2;
    localparam int PARTIAL_W = 10;
    localparam int CONT_W    = 6;

    // continuation counts loaded by the lead bytes
    localparam logic [PENDING_W-1:0] PENDING_NONE = 2'd0;
    localparam logic [PENDING_W-1:0] PENDING_ONE  = 2'd1;
    localparam logic [PENDING_W-1:0] PENDING_TWO  = 2'd2;

    // byte classes
    localparam logic [BYTE_W-1:0] BYTE_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_FIRST    = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_LAST     = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_FIRST    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_LAST     = 8'hEF;
    localparam logic [BYTE_W-1:0] ASCII_LAST     = 8'h7F;

    // one decoded result leaving the step logic
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              eos;
    } step_res_t;

endpackage

[rtl/utf8d_step.sv]
module utf8d_step
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
    output utf8d_pkg::step_res_t         res
);

    logic [utf8d_pkg::PENDING_W-1:0] pending_reg;
    logic [utf8d_pkg::PENDING_W-1:0] pending_next;
    logic [utf8d_pkg::PARTIAL_W-1:0] partial_reg;
    logic [utf8d_pkg::PARTIAL_W-1:0] partial_next;
    logic [utf8d_pkg::CODE_W-1:0]    acc;

    // partial bits shifted up, six new bits below
    assign acc = {partial_reg, byte_in[utf8d_pkg::CONT_W-1:0]};

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        res          = '0;
        if (byte_in == utf8d_pkg::BYTE_NUL)
        begin
            pending_next = utf8d_pkg::PENDING_NONE;
            partial_next = '0;
            res.valid    = 1'b1;
            res.eos      = 1'b1;
        end
        else if (pending_reg != utf8d_pkg::PENDING_NONE)
        begin
            pending_next = pending_reg - utf8d_pkg::PENDING_ONE;
            if (pending_reg == utf8d_pkg::PENDING_ONE)
            begin
                partial_next = '0;
                res.valid    = 1'b1;
                res.code     = acc;
            end
            else
            begin
                partial_next = acc[utf8d_pkg::PARTIAL_W-1:0];
            end
        end
        else if (byte_in inside {[utf8d_pkg::BYTE_NUL : utf8d_pkg::ASCII_LAST]})
        begin
            res.valid = 1'b1;
            res.code  = {{(utf8d_pkg::CODE_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
        end
        else if (byte_in inside {[utf8d_pkg::LEAD2_FIRST : utf8d_pkg::LEAD2_LAST]})
        begin
            pending_next = utf8d_pkg::PENDING_ONE;
            partial_next = {{(utf8d_pkg::PARTIAL_W-5){1'b0}}, byte_in[4:0]};
        end
        else if (byte_in inside {[utf8d_pkg::LEAD3_FIRST : utf8d_pkg::LEAD3_LAST]})
        begin
            pending_next = utf8d_pkg::PENDING_TWO;
            partial_next = {{(utf8d_pkg::PARTIAL_W-4){1'b0}}, byte_in[3:0]};
        end
        // stray continuation and f0-ff leads fall through with no result
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= utf8d_pkg::PENDING_NONE;
            partial_reg <= '0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

`ifndef SYNTHESIS
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("pending count out of range");

    a_idle_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == utf8d_pkg::PENDING_NONE) |-> (partial_reg == '0))
        else $error("partial bits left with no open sequence");

    a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && byte_in == utf8d_pkg::BYTE_NUL)
        |=> (pending_reg == utf8d_pkg::PENDING_NONE && partial_reg == '0))
        else $error("terminator did not clear state");
`endif

endmodule

[rtl/utf8d_result.sv]
module utf8d_result
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  utf8d_pkg::step_res_t         res,
    output logic                         valid,
    output logic [utf8d_pkg::CODE_W-1:0] code,
    output logic                         eos
);

    logic                         valid_reg;
    logic [utf8d_pkg::CODE_W-1:0] code_reg;
    logic                         eos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            code_reg <= res.code;
            eos_reg  <= res.eos;
        end
    end

    assign valid = valid_reg;
    assign code  = code_reg;
    assign eos   = eos_reg;

`ifndef SYNTHESIS
    a_eos_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && eos_reg) |-> (code_reg == '0))
        else $error("terminator word carries a nonzero code");
`endif

endmodule

[rtl/utf8_to_utf16_decoder.sv]
// utf-8 byte stream to 16-bit code unit decoder. one byte word enters per clock
// on text_* while text_stall is low, and at most one code unit word leaves on
// code_* for it: the byte is captured in an input register, decoded by a short
// combinational step against the pending count and partial bits, and the
// result lands in an output register. a new byte is accepted
// every cycle as long as the output register is empty or being taken, so the
// sustained rate is one byte per clock; the only feedback loop is the
// 2-bit pending count and 10-bit partial code, updated in the same cycle.
// ascii bytes give their value, leads c0-df and e0-ef open two- and three-byte
// sequences, any nonzero byte inside a sequence adds its low six bits, stray
// continuation bytes and leads f0-ff are dropped, and a zero byte gives code 0
// with end_of_string set and drops any unfinished sequence. surrogate pairs
// are not produced: four-byte characters are simply dropped.
module utf8_to_utf16_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    // byte words in
    input  logic                         text_valid,
    output logic                         text_stall,
    input  logic [utf8d_pkg::BYTE_W-1:0] text_byte,
    // code unit words out
    output logic                         code_valid,
    input  logic                         code_stall,
    output logic [utf8d_pkg::CODE_W-1:0] code_unit,
    output logic                         end_of_string
);

    // input register
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [utf8d_pkg::BYTE_W-1:0] in_byte_reg;

    // stage movement
    logic                         move;
    logic                         take_in;
    utf8d_pkg::step_res_t         step_res;

    // the decoded byte may leave the input register when the result slot is
    // empty or is being emptied this cycle
    assign move       = !code_valid || !code_stall;
    assign text_stall = in_valid_reg && !move;
    assign take_in    = text_valid && !text_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= text_byte;
        end
    end

    // decode step and sequence state
    utf8d_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_valid_reg && move),
        .byte_in (in_byte_reg),
        .res     (step_res)
    );

    // result register; a byte that gives no result leaves it empty
    utf8d_result u_result
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (move),
        .res   (in_valid_reg ? step_res : '0),
        .valid (code_valid),
        .code  (code_unit),
        .eos   (end_of_string)
    );

`ifndef SYNTHESIS
    // stall only ever comes from a held byte waiting on a full result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (in_valid_reg && code_valid && code_stall))
        else $error("input stalled with no blocked byte");

    // an accepted zero byte always shows up as a terminator word next
    a_nul_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && move && in_byte_reg == utf8d_pkg::BYTE_NUL)
        |=> (code_valid && end_of_string))
        else $error("zero byte did not give a terminator");
`endif

endmodule

[sim/tb_utf8_to_utf16_decoder.sv]
module tb_utf8_to_utf16_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // one decoded code unit word as it leaves the block
    typedef struct packed {
        logic [utf8d_pkg::CODE_W-1:0] code;
        logic                         eos;
    } unit_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,   // expectation comes from the predictor
        ROW_NO_UNIT,   // byte is known to give nothing
        ROW_UNIT       // expectation typed into the row
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [utf8d_pkg::BYTE_W-1:0] text_val;
        logic [utf8d_pkg::CODE_W-1:0] code;
        logic                         eos;
    } row_t;

    localparam int N_ROWS       = 26;
    localparam int RANDOM_BYTES = 524;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 8;

    logic                         clk;
    logic                         rst_n;
    logic                         text_valid;
    logic                         text_stall;
    logic [utf8d_pkg::BYTE_W-1:0] text_byte;
    logic                         code_valid;
    logic                         code_stall;
    logic [utf8d_pkg::CODE_W-1:0] code_unit;
    logic                         end_of_string;

    // predictor state: continuation bytes still owed and the bits gathered
    logic [utf8d_pkg::PENDING_W-1:0] seq_left;
    logic [utf8d_pkg::PARTIAL_W-1:0] seq_bits;

    // code units the block still owes, oldest first
    unit_t awaited_units [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int bytes_sent;
    int units_checked;
    int ends_checked;
    int random_sent;

    row_t directed_rows [N_ROWS];

    utf8_to_utf16_decoder u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout: %0d code units still awaited", awaited_units.size());
        $display("utf8_to_utf16_decoder: mismatch");
        $finish;
    end

    // decode one accepted byte against the predictor state
    function automatic void decode_byte(input logic [utf8d_pkg::BYTE_W-1:0] b,
                                        output logic has_unit, output unit_t u);
        logic [utf8d_pkg::CODE_W-1:0] acc;
        has_unit = 1'b0;
        u        = '0;
        acc      = '0;
        if (b == utf8d_pkg::BYTE_NUL)
        begin
            // terminator always wins and drops any open sequence
            seq_left = utf8d_pkg::PENDING_NONE;
            seq_bits = '0;
            has_unit = 1'b1;
            u.eos    = 1'b1;
        end
        else if (seq_left != utf8d_pkg::PENDING_NONE)
        begin
            // any nonzero byte counts as continuation, marker bits ignored
            acc      = {seq_bits, b[utf8d_pkg::CONT_W-1:0]};
            seq_left = seq_left - 1'b1;
            if (seq_left == utf8d_pkg::PENDING_NONE)
            begin
                seq_bits = '0;
                has_unit = 1'b1;
                u.code   = acc;
            end
            else
                seq_bits = acc[utf8d_pkg::PARTIAL_W-1:0];
        end
        else if (b[7] == 1'b0)
        begin
            // plain ascii
            has_unit = 1'b1;
            u.code   = {8'h00, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            // two-byte lead, overlong c0/c1 included
            seq_bits = {5'b0, b[4:0]};
            seq_left = utf8d_pkg::PENDING_ONE;
        end
        else if (b[7:4] == 4'b1110)
        begin
            // three-byte lead
            seq_bits = {6'b0, b[3:0]};
            seq_left = utf8d_pkg::PENDING_TWO;
        end
        // stray continuation and f0-ff leads fall through silently
    endfunction

    // continuation byte, now and then with broken marker bits
    function automatic logic [utf8d_pkg::BYTE_W-1:0] cont_byte();
        if ($urandom_range(7) == 0)
            return utf8d_pkg::BYTE_W'($urandom_range(1, 255));
        return {2'b10, utf8d_pkg::CONT_W'($urandom)};
    endfunction

    // offer one byte word, wait for it to be taken, record what it should give
    task automatic send_word(input logic [utf8d_pkg::BYTE_W-1:0] val,
                             input row_kind_t kind, input unit_t typed_unit);
        logic  has_unit;
        unit_t u;
        // random gaps before the word
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= val;
        // accepted on the first rising edge with stall low
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        decode_byte(val, has_unit, u);
        case (kind)
            ROW_PREDICT: if (has_unit) awaited_units.push_back(u);
            ROW_UNIT:    awaited_units.push_back(typed_unit);
            default:     ;
        endcase
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [utf8d_pkg::BYTE_W-1:0] val);
        send_word(val, ROW_PREDICT, '0);
        random_sent++;
    endtask

    // mostly well-formed text with random content, some noise and broken runs
    task automatic send_random_text(input int target);
        int roll;
        int n;
        while (random_sent < target)
        begin
            // idle pattern: receiver-heavy, sender-heavy, then none
            if (random_sent >= (2 * target) / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (random_sent >= target / 3)
            begin
                send_idle_pct  = 59;
                recv_stall_pct = 18;
            end
            roll = $urandom_range(99);
            if (roll < 30)
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(1, 127)));
            else if (roll < 50)
            begin
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(utf8d_pkg::LEAD2_FIRST,
                                                            utf8d_pkg::LEAD2_LAST)));
                send_byte(cont_byte());
            end
            else if (roll < 70)
            begin
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(utf8d_pkg::LEAD3_FIRST,
                                                            utf8d_pkg::LEAD3_LAST)));
                send_byte(cont_byte());
                send_byte(cont_byte());
            end
            else if (roll < 78)
                send_byte(utf8d_pkg::BYTE_NUL);
            else if (roll < 86)
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(255)));
            else if (roll < 93)
            begin
                // sequence cut short by the terminator
                if ($urandom_range(1))
                    send_byte(utf8d_pkg::BYTE_W'($urandom_range(utf8d_pkg::LEAD2_FIRST,
                                                                utf8d_pkg::LEAD2_LAST)));
                else
                begin
                    send_byte(utf8d_pkg::BYTE_W'($urandom_range(utf8d_pkg::LEAD3_FIRST,
                                                                utf8d_pkg::LEAD3_LAST)));
                    n = $urandom_range(1);
                    if (n != 0)
                        send_byte(cont_byte());
                end
                send_byte(utf8d_pkg::BYTE_NUL);
            end
            else if ($urandom_range(1))
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(8'h80, 8'hBF)));
            else
                send_byte(utf8d_pkg::BYTE_W'($urandom_range(8'hF0, 8'hFF)));
        end
    endtask

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
            code_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare every taken code unit word with the oldest expectation
    always @(posedge clk)
    begin
        unit_t want;
        if (rst_n && code_valid && !code_stall)
        begin
            if (awaited_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected code unit %h eos %b", code_unit, end_of_string);
            end
            else
            begin
                want = awaited_units.pop_front();
                units_checked++;
                if (end_of_string)
                    ends_checked++;
                if (code_unit !== want.code || end_of_string !== want.eos)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("code unit %0d: got %h eos %b, expected %h eos %b",
                                 units_checked, code_unit, end_of_string,
                                 want.code, want.eos);
                end
            end
        end
    end

    initial
    begin
        // directed rows: extremes, every byte class, the corner cases
        directed_rows = '{
            '{ROW_UNIT,    8'h00, 16'h0000, 1'b1},  // terminator straight after reset
            '{ROW_UNIT,    8'h7F, 16'h007F, 1'b0},  // top ascii
            '{ROW_UNIT,    8'h01, 16'h0001, 1'b0},  // bottom ascii
            '{ROW_NO_UNIT, 8'h80, 16'h0000, 1'b0},  // stray continuation, low end
            '{ROW_NO_UNIT, 8'hBF, 16'h0000, 1'b0},  // stray continuation, high end
            '{ROW_NO_UNIT, 8'hF0, 16'h0000, 1'b0},  // four-byte lead dropped
            '{ROW_NO_UNIT, 8'hFF, 16'h0000, 1'b0},  // invalid lead dropped
            '{ROW_PREDICT, 8'hC0, 16'h0000, 1'b0},  // overlong lead accepted
            '{ROW_PREDICT, 8'h80, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hDF, 16'h0000, 1'b0},  // largest two-byte value
            '{ROW_PREDICT, 8'hBF, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hE0, 16'h0000, 1'b0},  // smallest three-byte value
            '{ROW_PREDICT, 8'h80, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'h80, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hEF, 16'h0000, 1'b0},  // largest three-byte value
            '{ROW_PREDICT, 8'hBF, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hBF, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hE2, 16'h0000, 1'b0},  // continuation markers not checked
            '{ROW_PREDICT, 8'h41, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hFF, 16'h0000, 1'b0},
            '{ROW_PREDICT, 8'hC3, 16'h0000, 1'b0},  // open two-byte cut by terminator
            '{ROW_UNIT,    8'h00, 16'h0000, 1'b1},
            '{ROW_PREDICT, 8'hE5, 16'h0000, 1'b0},  // open three-byte cut by terminator
            '{ROW_PREDICT, 8'h9C, 16'h0000, 1'b0},
            '{ROW_UNIT,    8'h00, 16'h0000, 1'b1},
            '{ROW_UNIT,    8'h41, 16'h0041, 1'b0}   // state cleared afterwards
        };

        rst_n          = 1'b0;
        text_valid     = 1'b0;
        text_byte      = '0;
        code_stall     = 1'b0;
        seq_left       = utf8d_pkg::PENDING_NONE;
        seq_bits       = '0;
        send_idle_pct  = 18;
        recv_stall_pct = 59;
        mismatches     = 0;
        bytes_sent     = 0;
        units_checked  = 0;
        ends_checked   = 0;
        random_sent    = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, sender idling lightly and receiver heavily
        foreach (directed_rows[i])
            send_word(directed_rows[i].text_val, directed_rows[i].kind,
                      '{code: directed_rows[i].code, eos: directed_rows[i].eos});

        send_random_text(RANDOM_BYTES);
        text_valid <= 1'b0;

        // drain, then leave room for anything the block should not send
        while (awaited_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d code units of which %0d terminators",
                 bytes_sent, units_checked, ends_checked);
        $display("idle patterns: receiver-heavy, sender-heavy, none");
        if (mismatches == 0 && awaited_units.size() == 0)
            $display("utf8_to_utf16_decoder: match");
        else
            $display("utf8_to_utf16_decoder: mismatch");
        $finish;
    end

endmodule
